// File: hw/rtl/swrm_pkg.sv
// Shared types and constants of the sliding window range maximum unit.
`default_nettype none

package swrm_pkg;

  localparam logic signed [31:0] MOST_NEG   = 32'sh8000_0000;
  localparam logic               MODE_QUERY = 1'b1;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_Q_INIT,
    OP_Q_RD,
    OP_Q_STEP,
    OP_RESULT,
    OP_COPY_INIT,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_BUILD_INIT,
    OP_BUILD_RD,
    OP_BUILD_WR,
    OP_PUSH_WR,
    OP_UP_RD,
    OP_UP_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic q_skip;
    logic q_continue;
    logic need_wrap;
    logic copy_last;
    logic build_done;
    logic up_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/swrm_if.sv
// Channel interfaces: input items, results and the offset register write.
`default_nettype none

interface swrm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] sample;
  logic signed [8:0]  first_index;
  logic signed [8:0]  last_index;
  modport source (output valid, mode, sample, first_index, last_index, input ready);
  modport sink   (input valid, mode, sample, first_index, last_index, output ready);
endinterface

interface swrm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] range_max;
  logic               range_error;
  modport source (output valid, range_max, range_error, input ready);
  modport sink   (input valid, range_max, range_error, output ready);
endinterface

interface swrm_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] window_offset;
  modport source (output valid, window_offset, input ready);
  modport sink   (input valid, window_offset, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sliding_window_range_max_unit.sv
// Top level: sliding window max segment tree, push and range query.
//
//  channel  dir  payload                                   transfer when
//  in_ch    in   mode, sample, first_index, last_index     valid & ready
//  out_ch   out  range_max, range_error (queries only)     valid & ready
//  cfg_ch   in   window_offset                             valid & ready (always ready)
//
//  A push writes the new leaf and then walks up its ancestors, a read then a write
//  per node through one node memory. A query reads, steps and tests once per tree
//  level walked. A push that hits the end of the four-window span first copies the
//  window (a read and a write per entry) and rebuilds the inner nodes above it
//  (a read and a write per node). After reset a clearing pass writes all
//  8*WINDOW (rounded to a power of two) node entries, one per cycle, before
//  in_ch.ready rises. A finished result waits in the output register while the next
//  item is taken; a second query result stalls until out_ch frees.
`default_nettype none

module sliding_window_range_max_unit
  import swrm_pkg::*;
#(
  parameter int WINDOW = 256
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  swrm_in_if.sink     in_ch,
  swrm_out_if.source  out_ch,
  swrm_cfg_if.sink    cfg_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // offset register writes are always taken
  assign cfg_ch.ready = 1'b1;

  swrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swrm_datapath #(.WINDOW(WINDOW)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_mode   (in_ch.mode),
    .in_sample (in_ch.sample),
    .in_first  (in_ch.first_index),
    .in_last   (in_ch.last_index),
    .cfg_we    (cfg_ch.valid),
    .cfg_offset(cfg_ch.window_offset),
    .res_max   (out_ch.range_max),
    .res_err   (out_ch.range_error)
  );

endmodule

`default_nettype wire

// File: hw/rtl/swrm_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module swrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: hw/rtl/swrm_datapath.sv
// Datapath: tree node memory, pointers, window position, query accumulator.
`default_nettype none

module swrm_datapath
  import swrm_pkg::*;
#(
  parameter int WINDOW = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic               in_mode,
  input  wire logic signed [31:0] in_sample,
  input  wire logic signed [8:0]  in_first,
  input  wire logic signed [8:0]  in_last,
  input  wire logic               cfg_we,
  input  wire logic [8:0]         cfg_offset,
  output logic signed [31:0]      res_max,
  output logic                    res_err
);

  localparam int SPAN        = 4 * WINDOW;
  localparam int TREE_LEAVES = 2 ** $clog2(SPAN);
  localparam int NW          = $clog2(TREE_LEAVES) + 1;
  localparam int DEPTH       = 2 * TREE_LEAVES;
  localparam int WPW         = $clog2(SPAN);
  localparam int AW          = ($clog2(WINDOW + 1) + 1 > 11) ? $clog2(WINDOW + 1) + 1 : 11;

  localparam logic [NW-1:0]        LEAF_BASE = NW'(TREE_LEAVES);
  localparam logic [NW-1:0]        WIN_BASE  = NW'(TREE_LEAVES + WINDOW);
  localparam logic [NW-1:0]        BUILD_LO  = NW'(TREE_LEAVES / 2);
  localparam logic [NW-1:0]        BUILD_HI  = NW'((TREE_LEAVES + WINDOW - 1) / 2);
  localparam logic [NW-1:0]        COPY_LAST = NW'(WINDOW - 1);
  localparam logic [NW-1:0]        ROOT      = NW'(1);
  localparam logic [NW-1:0]        ALL_ONES  = {NW{1'b1}};
  localparam logic [WPW-1:0]       WRAP_AT   = WPW'(SPAN - WINDOW);
  localparam logic signed [AW-1:0] LAST_IDX  = AW'(WINDOW - 1);

  // control registers
  logic [NW-1:0]  ptr_r, ptr_nxt;
  logic [WPW-1:0] wp_r, wp_nxt;
  logic [8:0]     offset_r, offset_nxt;
  // payload registers
  logic [NW-1:0]      hi_r, hi_nxt;
  logic [NW-1:0]      base_r, base_nxt;
  logic signed [31:0] top_r, top_nxt;
  logic               err_r, err_nxt;
  logic               mode_r;
  logic signed [31:0] sample_r;
  logic signed [8:0]  first_r, last_r;
  logic signed [31:0] res_max_r;
  logic               res_err_r;

  logic                 we;
  logic [NW-1:0]        waddr, raddr_a, raddr_b;
  logic signed [31:0]   wdata, rd_a, rd_b;
  logic signed [31:0]   child_max, lo_pick, hi_pick, acc_max;
  logic signed [AW-1:0] a_s, b_s;
  logic                 empty, range_bad;
  logic [NW:0]          lo_inc;
  logic [NW-1:0]        hi_dec;

  swrm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  // range check on the captured query
  assign a_s       = AW'(signed'({1'b0, offset_r})) + AW'(first_r);
  assign b_s       = AW'(signed'({1'b0, offset_r})) + AW'(last_r);
  assign empty     = first_r > last_r;
  assign range_bad = !empty && ((a_s < 0) || (b_s > LAST_IDX));

  assign child_max = (rd_a > rd_b) ? rd_a : rd_b;
  assign lo_pick   = ptr_r[0] ? rd_a : MOST_NEG;
  assign hi_pick   = hi_r[0] ? MOST_NEG : rd_b;
  assign acc_max   = (lo_pick > top_r) ? lo_pick : top_r;
  assign lo_inc    = {1'b0, ptr_r} + (NW+1)'(ptr_r[0]);
  assign hi_dec    = hi_r - NW'(!hi_r[0]);

  always_comb begin
    stat.clear_last = ptr_r == ALL_ONES;
    stat.is_query   = mode_r == MODE_QUERY;
    stat.q_skip     = empty || range_bad;
    stat.q_continue = ptr_r <= hi_r;
    stat.need_wrap  = wp_r >= WRAP_AT;
    stat.copy_last  = ptr_r == COPY_LAST;
    stat.build_done = (ptr_r == hi_r) && (base_r == ROOT);
    stat.up_done    = ptr_r == ROOT;
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    wp_nxt     = wp_r;
    offset_nxt = cfg_we ? cfg_offset : offset_r;
    hi_nxt     = hi_r;
    base_nxt   = base_r;
    top_nxt    = top_r;
    err_nxt    = err_r;
    we         = 1'b0;
    waddr      = ptr_r;
    wdata      = child_max;
    raddr_a    = {ptr_r[NW-2:0], 1'b0};
    raddr_b    = {ptr_r[NW-2:0], 1'b1};
    unique case (cmd.op)
      OP_CLEAR: begin
        we      = 1'b1;
        wdata   = MOST_NEG;
        ptr_nxt = ptr_r + ROOT;
      end
      OP_Q_INIT: begin
        top_nxt = MOST_NEG;
        err_nxt = range_bad;
        ptr_nxt = LEAF_BASE + NW'(wp_r) + NW'(a_s);
        hi_nxt  = LEAF_BASE + NW'(wp_r) + NW'(b_s);
      end
      OP_Q_RD: begin
        raddr_a = ptr_r;
        raddr_b = hi_r;
      end
      OP_Q_STEP: begin
        top_nxt = (hi_pick > acc_max) ? hi_pick : acc_max;
        ptr_nxt = lo_inc[NW:1];
        hi_nxt  = {1'b0, hi_dec[NW-1:1]};
      end
      OP_COPY_INIT: ptr_nxt = '0;
      OP_COPY_RD:   raddr_a = LEAF_BASE + NW'(wp_r) + ptr_r;
      OP_COPY_WR: begin
        we      = 1'b1;
        waddr   = LEAF_BASE + ptr_r;
        wdata   = rd_a;
        ptr_nxt = ptr_r + ROOT;
      end
      OP_BUILD_INIT: begin
        wp_nxt   = '0;
        base_nxt = BUILD_LO;
        ptr_nxt  = BUILD_LO;
        hi_nxt   = BUILD_HI;
      end
      OP_BUILD_WR: begin
        we = 1'b1;
        if (ptr_r == hi_r) begin
          base_nxt = base_r >> 1;
          hi_nxt   = hi_r >> 1;
          ptr_nxt  = base_r >> 1;
        end else begin
          ptr_nxt = ptr_r + ROOT;
        end
      end
      OP_PUSH_WR: begin
        we      = 1'b1;
        waddr   = WIN_BASE + NW'(wp_r);
        wdata   = sample_r;
        ptr_nxt = (WIN_BASE + NW'(wp_r)) >> 1;
        wp_nxt  = wp_r + WPW'(1);
      end
      OP_UP_WR: begin
        we      = 1'b1;
        ptr_nxt = ptr_r >> 1;
      end
      OP_NONE, OP_CAPTURE, OP_RESULT, OP_BUILD_RD, OP_UP_RD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      wp_r     <= '0;
      offset_r <= '0;
    end else begin
      ptr_r    <= ptr_nxt;
      wp_r     <= wp_nxt;
      offset_r <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r   <= hi_nxt;
    base_r <= base_nxt;
    top_r  <= top_nxt;
    err_r  <= err_nxt;
    if (cmd.op == OP_CAPTURE) begin
      mode_r   <= in_mode;
      sample_r <= in_sample;
      first_r  <= in_first;
      last_r   <= in_last;
    end
    if (cmd.op == OP_RESULT) begin
      res_max_r <= top_r;
      res_err_r <= err_r;
    end
  end

  assign res_max = res_max_r;
  assign res_err = res_err_r;

endmodule

`default_nettype wire

// File: hw/rtl/swrm_ctrl.sv
// Sequencer: clearing pass, push with wrap copy and rebuild, query walk.
`default_nettype none

module swrm_ctrl
  import swrm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_COPY_RD,
    S_COPY_WR,
    S_BUILD_INIT,
    S_BUILD_RD,
    S_BUILD_WR,
    S_PUSH,
    S_UP_RD,
    S_UP_WR,
    S_Q_RD,
    S_Q_STEP,
    S_Q_TEST,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (stat.is_query) begin
          cmd.op    = OP_Q_INIT;
          state_nxt = stat.q_skip ? S_RESULT : S_Q_RD;
        end else if (stat.need_wrap) begin
          cmd.op    = OP_COPY_INIT;
          state_nxt = S_COPY_RD;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_COPY_RD: begin
        cmd.op    = OP_COPY_RD;
        state_nxt = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.op    = OP_COPY_WR;
        state_nxt = stat.copy_last ? S_BUILD_INIT : S_COPY_RD;
      end
      S_BUILD_INIT: begin
        cmd.op    = OP_BUILD_INIT;
        state_nxt = S_BUILD_RD;
      end
      S_BUILD_RD: begin
        cmd.op    = OP_BUILD_RD;
        state_nxt = S_BUILD_WR;
      end
      S_BUILD_WR: begin
        cmd.op    = OP_BUILD_WR;
        state_nxt = stat.build_done ? S_PUSH : S_BUILD_RD;
      end
      S_PUSH: begin
        cmd.op    = OP_PUSH_WR;
        state_nxt = S_UP_RD;
      end
      S_UP_RD: begin
        cmd.op    = OP_UP_RD;
        state_nxt = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.op    = OP_UP_WR;
        state_nxt = stat.up_done ? S_IDLE : S_UP_RD;
      end
      S_Q_RD: begin
        cmd.op    = OP_Q_RD;
        state_nxt = S_Q_STEP;
      end
      S_Q_STEP: begin
        cmd.op    = OP_Q_STEP;
        state_nxt = S_Q_TEST;
      end
      S_Q_TEST: begin
        state_nxt = stat.q_continue ? S_Q_RD : S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.op        = OP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
